[rtl/sit_pkg.sv]
package sit_pkg;

	// Operation codes carried in the request's func field
	localparam logic [1:0] FUNC_START   = 2'd0;
	localparam logic [1:0] FUNC_LOOKUP  = 2'd1;
	localparam logic [1:0] FUNC_DESTROY = 2'd2;

	// Status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// One request
	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] user_ident;
		logic [31:0] provider_ident;
		logic [31:0] session_key;
	} req_t;

	// One result
	typedef struct packed {
		logic        status;
		logic [31:0] value;
		logic        removed;
		logic [8:0]  active_count;
	} rsp_t;

	// One table word as kept in memory
	typedef struct packed {
		logic        vld;
		logic [31:0] sess;
		logic [31:0] user;
		logic [31:0] prov;
	} entry_t;

endpackage

[rtl/session_id_table_top.sv]
// Session id table. Each request is handled alone: the block scans the table memory
// from slot 0 upward, one slot per cycle through its single read port, and stops at
// the first free slot (start) or the first valid slot whose id matches (lookup,
// destroy). When a scan ends, on a hit or on a miss at the last slot, its result is
// loaded into the result register; an unused function code loads its result when the
// request is accepted. The next request can be accepted once its result has moved to
// the output register. After reset the block clears the valid marks by writing every
// slot once, and stalls requests until that pass is done. The result register
// lets a new request be accepted while the previous result waits; a second finished
// result holds the block until the receiver takes the first.
module session_id_table_top #(
	parameter int TABLE_DEPTH = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  sit_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output sit_pkg::rsp_t rsp
);
	import sit_pkg::*;

	localparam int AW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNTW = AW + 1;
	localparam int CW   = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_SCAN, S_DONE} state_t;

	state_t             state_q;
	logic [AW-1:0]      clr_q;
	logic [CNTW-1:0]    rd_cnt_q;
	logic               pend_s1;
	logic [AW-1:0]      addr_s1;
	logic [CW-1:0]      live_q;
	logic [31:0]        next_q;
	req_t               req_q;
	rsp_t               res_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	// table memory
	entry_t             mem [TABLE_DEPTH];
	entry_t             rd_data_s1;
	logic               we;
	logic [AW-1:0]      waddr;
	entry_t             wdata;

	// scan control
	logic               issue;
	logic               match;
	logic               hit;
	logic               miss;
	logic [31:0]        new_id;
	logic [CW-1:0]      live_d;
	logic [CW+8:0]      cnt_ext;
	logic [CW+8:0]      cnt_cur;
	rsp_t               res_d;
	logic               rsp_load;

	assign issue  = (state_q == S_SCAN) && (rd_cnt_q < CNTW'(TABLE_DEPTH));
	assign new_id = (next_q == 32'd0) ? 32'd1 : next_q;
	assign cnt_cur = {9'd0, live_q};

	// slot test on the word read for addr_s1
	always_comb begin
		if (req_q.func == FUNC_START) begin
			match = !rd_data_s1.vld;
		end else begin
			match = rd_data_s1.vld && (rd_data_s1.sess == req_q.session_key);
		end
	end

	assign hit  = (state_q == S_SCAN) && pend_s1 && match;
	assign miss = (state_q == S_SCAN) && pend_s1 && !match
		&& (addr_s1 == AW'(TABLE_DEPTH - 1));

	// new live count and result of the finishing cycle
	always_comb begin
		live_d = live_q;
		if (hit && (req_q.func == FUNC_START)) begin
			live_d = live_q + CW'(1);
		end else if (hit && (req_q.func == FUNC_DESTROY)) begin
			live_d = live_q - CW'(1);
		end
		cnt_ext = {9'd0, live_d};
		res_d.status       = STATUS_OK;
		res_d.value        = 32'd0;
		res_d.removed      = 1'b0;
		res_d.active_count = cnt_ext[8:0];
		case (req_q.func)
			FUNC_START: begin
				if (hit) begin
					res_d.value = new_id;
				end else begin
					res_d.status = STATUS_FULL;
				end
			end
			FUNC_LOOKUP: begin
				if (hit) begin
					res_d.value = rd_data_s1.user;
				end
			end
			FUNC_DESTROY: begin
				res_d.removed = hit;
			end
			default: begin
			end
		endcase
	end

	// memory write: clearing pass, new entry, or valid mark dropped
	always_comb begin
		we    = 1'b0;
		waddr = addr_s1;
		wdata = rd_data_s1;
		if (state_q == S_CLEAR) begin
			we    = 1'b1;
			waddr = clr_q;
			wdata = '0;
		end else if (hit && (req_q.func == FUNC_START)) begin
			we         = 1'b1;
			wdata.vld  = 1'b1;
			wdata.sess = new_id;
			wdata.user = req_q.user_ident;
			wdata.prov = req_q.provider_ident;
		end else if (hit && (req_q.func == FUNC_DESTROY)) begin
			we        = 1'b1;
			wdata.vld = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_data_s1 <= mem[rd_cnt_q[AW-1:0]];
	end

	// request payload and scan address pipeline
	always_ff @(posedge clk) begin
		addr_s1 <= rd_cnt_q[AW-1:0];
		if (req_valid && !req_stall) begin
			req_q <= req;
		end
	end

	// finished result moves to the output register once it is free
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || !rsp_stall);

	// control state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			rd_cnt_q    <= '0;
			pend_s1     <= 1'b0;
			live_q      <= '0;
			next_q      <= 32'd0;
			res_q       <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			pend_s1 <= issue;
			if (issue) begin
				rd_cnt_q <= rd_cnt_q + CNTW'(1);
			end
			if (rsp_load) begin
				rsp_q       <= res_q;
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(TABLE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					rd_cnt_q <= '0;
					if (req_valid) begin
						if (req.func inside {FUNC_START, FUNC_LOOKUP, FUNC_DESTROY}) begin
							state_q <= S_SCAN;
						end else begin
							res_q.status       <= STATUS_OK;
							res_q.value        <= 32'd0;
							res_q.removed      <= 1'b0;
							res_q.active_count <= cnt_cur[8:0];
							state_q            <= S_DONE;
						end
					end
				end
				S_SCAN: begin
					if (hit || miss) begin
						res_q   <= res_d;
						live_q  <= live_d;
						state_q <= S_DONE;
						if (hit && (req_q.func == FUNC_START)) begin
							next_q <= new_id + 32'd1;
						end
					end
				end
				S_DONE: begin
					if (rsp_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// live count never exceeds the table size
	a_live_bound: assert property (@(posedge clk) disable iff (!arst_n)
		live_q <= CW'(TABLE_DEPTH))
		else $error("live count above table depth");

	// no request taken while the clearing pass runs
	a_clear_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CLEAR) |-> req_stall)
		else $error("request accepted during clear pass");

	// table full only when every slot is live
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_DONE) && (res_q.status == STATUS_FULL))
		|-> (live_q == CW'(TABLE_DEPTH)))
		else $error("table full reported with a free slot");

endmodule

[dv/tb_session_id_table_top.sv]
`timescale 1ns / 1ps

module tb_session_id_table_top;
	import sit_pkg::*;

	localparam int TABLE_SLOTS = 256;
	localparam int CLK_HALF = 6;
	localparam int RANDOM_ITEMS = 1030;
	localparam int HOLD_CYCLES = 400;
	localparam longint TIMEOUT_NS = 64'd2_000_000 * 12;

	// Code 3 is not decoded by the block: it must act as a no-op
	localparam logic [1:0] FUNC_NONE = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	bit sender_calm;
	bit hold_pending;

	// Shadow copy of the session table; predicts one result per request
	class session_table_shadow;
		logic [31:0] slot_session [TABLE_SLOTS];
		logic [31:0] slot_user [TABLE_SLOTS];
		bit slot_live [TABLE_SLOTS];
		int unsigned live_total;
		logic [31:0] id_counter;
		rsp_t results_due [$];
		int unsigned errors;
		int unsigned starts_done, starts_refused;
		int unsigned lookups_hit, lookups_missed;
		int unsigned destroys_done, destroys_missed;
		int unsigned unused_ops;

		function new();
			id_counter = '0;
		endfunction

		// Lowest live slot holding the key, -1 on a miss
		function int slot_of(logic [31:0] key);
			for (int i = 0; i < TABLE_SLOTS; i++) begin
				if (slot_live[i] && slot_session[i] == key) return i;
			end
			return -1;
		endfunction

		function void note_request(req_t item);
			rsp_t want;
			int slot;
			logic [31:0] minted;
			want = '0;
			want.status = STATUS_OK;
			slot = -1;
			case (item.func)
				FUNC_START: begin
					for (int i = TABLE_SLOTS - 1; i >= 0; i--) begin
						if (!slot_live[i]) slot = i;
					end
					if (slot < 0) begin
						want.status = STATUS_FULL;
						starts_refused++;
					end else begin
						// id 0 is never handed out
						minted = (id_counter == '0) ? 32'd1 : id_counter;
						slot_session[slot] = minted;
						slot_user[slot] = item.user_ident;
						slot_live[slot] = 1'b1;
						live_total++;
						id_counter = minted + 32'd1;
						want.value = minted;
						starts_done++;
					end
				end
				FUNC_LOOKUP: begin
					slot = slot_of(item.session_key);
					if (slot >= 0) begin
						want.value = slot_user[slot];
						lookups_hit++;
					end else begin
						lookups_missed++;
					end
				end
				FUNC_DESTROY: begin
					slot = slot_of(item.session_key);
					if (slot >= 0) begin
						slot_live[slot] = 1'b0;
						live_total--;
						want.removed = 1'b1;
						destroys_done++;
					end else begin
						destroys_missed++;
					end
				end
				default: begin
					unused_ops++;
				end
			endcase
			want.active_count = 9'(live_total);
			results_due.push_back(want);
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (results_due.size() == 0) begin
				$error("result with nothing expected: value %h count %0d",
					got.value, got.active_count);
				errors++;
				return;
			end
			want = results_due.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				errors++;
			end
			if (got.value !== want.value) begin
				$error("value: expected %h, got %h", want.value, got.value);
				errors++;
			end
			if (got.removed !== want.removed) begin
				$error("removed: expected %0d, got %0d", want.removed, got.removed);
				errors++;
			end
			if (got.active_count !== want.active_count) begin
				$error("active_count: expected %0d, got %0d",
					want.active_count, got.active_count);
				errors++;
			end
		endfunction

		// Mostly live ids, some random or stale ones, now and then zero
		function logic [31:0] pick_key();
			int unsigned roll;
			int unsigned slot;
			roll = $urandom_range(99);
			if (live_total != 0 && roll < 75) begin
				slot = $urandom_range(TABLE_SLOTS - 1);
				while (!slot_live[slot]) slot = (slot + 1) % TABLE_SLOTS;
				return slot_session[slot];
			end
			if (roll < 88) return $urandom;
			if (roll < 96 && id_counter > 32'd1) return $urandom_range(id_counter - 32'd1, 1);
			return '0;
		endfunction
	endclass

	session_table_shadow book = new();

	session_id_table_top #(
		.TABLE_DEPTH(TABLE_SLOTS)
	) dut (
		.clk,
		.arst_n,
		.req_valid,
		.req_stall,
		.req,
		.rsp_valid,
		.rsp_stall,
		.rsp
	);

	always #(CLK_HALF) clk = ~clk;

	// Gap length: mostly none or short, rarely long
	function automatic int unsigned idle_len(bit calm);
		int unsigned roll;
		if (calm) return 0;
		roll = $urandom_range(99);
		if (roll < 55) return 0;
		if (roll < 85) return $urandom_range(3, 1);
		if (roll < 97) return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	// Random request; the mix leans toward starts while the table grows
	function automatic req_t make_request(bit growing);
		req_t item;
		int unsigned roll;
		item.user_ident = $urandom;
		item.provider_ident = $urandom;
		item.session_key = book.pick_key();
		roll = $urandom_range(99);
		if (roll < 4) item.func = FUNC_NONE;
		else if (roll < (growing ? 70 : 18)) item.func = FUNC_START;
		else if (roll < (growing ? 88 : 45)) item.func = FUNC_LOOKUP;
		else item.func = FUNC_DESTROY;
		return item;
	endfunction

	// Offer one request, hold it through stalls, note it once accepted
	task automatic send_req(input req_t item);
		int unsigned gap;
		gap = idle_len(sender_calm);
		if (gap != 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req = item;
		req_valid = 1'b1;
		forever begin
			@(posedge clk);
			if (!req_stall) break;
		end
		book.note_request(item);
		@(negedge clk);
	endtask

	task automatic send_fields(input logic [1:0] code, input logic [31:0] user,
		input logic [31:0] prov, input logic [31:0] key);
		req_t item;
		item.func = code;
		item.user_ident = user;
		item.provider_ident = prov;
		item.session_key = key;
		send_req(item);
	endtask

	// Result checking at the accepting edge
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) book.check_result(rsp);
	end

	// Result side: random stalls, calm stretches, and long holds on request
	initial begin : result_sink
		int unsigned span;
		bit calm;
		rsp_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			calm = ($urandom_range(3) == 0);
			repeat ($urandom_range(60, 20)) begin
				@(negedge clk);
				if (hold_pending) begin
					hold_pending = 1'b0;
					rsp_stall = 1'b1;
					repeat (HOLD_CYCLES) @(negedge clk);
				end
				span = idle_len(calm);
				if (span != 0) begin
					rsp_stall = 1'b1;
					repeat (span) @(negedge clk);
				end
				rsp_stall = 1'b0;
			end
		end
	end

	initial begin : run_limit
		#(TIMEOUT_NS);
		$display("Regression FAIL");
		$finish;
	end

	initial begin : request_source
		req_t item;
		bit growing;
		int unsigned goal;
		int unsigned over_tries;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		sender_calm = 1'b0;
		hold_pending = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Empty table: misses and the unused code
		send_fields(FUNC_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
		send_fields(FUNC_DESTROY, 32'h0, 32'h0, 32'hFFFF_FFFF);
		send_fields(FUNC_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// First start mints 1 from a zero counter; field extremes
		send_fields(FUNC_START, 32'h0, 32'h0, 32'hFFFF_FFFF);
		send_fields(FUNC_START, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
		send_fields(FUNC_START, 32'h5A5A_A5A5, 32'hA5A5_5A5A, 32'h0);
		send_fields(FUNC_LOOKUP, 32'h0, 32'h0, 32'd1);
		send_fields(FUNC_LOOKUP, 32'h0, 32'h0, 32'd2);
		send_fields(FUNC_LOOKUP, 32'h0, 32'h0, 32'd3);
		send_fields(FUNC_LOOKUP, 32'h0, 32'h0, 32'hFFFF_FFFF);
		// Destroy hit, then the same key misses
		send_fields(FUNC_DESTROY, 32'h0, 32'h0, 32'd1);
		send_fields(FUNC_DESTROY, 32'h0, 32'h0, 32'd1);
		send_fields(FUNC_LOOKUP, 32'h0, 32'h0, 32'd1);
		// Freed slot 0 is reused first
		send_fields(FUNC_START, 32'h1234_5678, 32'h8765_4321, 32'h0);
		send_fields(FUNC_LOOKUP, 32'h0, 32'h0, 32'd4);
		send_fields(FUNC_NONE, 32'h0, 32'h0, 32'h0);
		send_fields(FUNC_DESTROY, 32'h0, 32'h0, 32'd3);
		send_fields(FUNC_DESTROY, 32'h0, 32'h0, 32'd2);
		send_fields(FUNC_DESTROY, 32'h0, 32'h0, 32'd4);
		send_fields(FUNC_LOOKUP, 32'h0, 32'h0, 32'h0);

		// Random phases: grow (first one to a full table), then shrink
		growing = 1'b1;
		goal = TABLE_SLOTS;
		over_tries = 0;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 40 == 0) sender_calm = ($urandom_range(3) == 0);
			if (n == 300 || n == 750) begin
				hold_pending = 1'b1;
				sender_calm = 1'b1;
			end
			if (growing) begin
				if (book.live_total >= goal && (goal < TABLE_SLOTS || over_tries >= 3)) begin
					growing = 1'b0;
					over_tries = 0;
					goal = $urandom_range(1) ? 0 : $urandom_range(book.live_total / 2, 0);
				end
			end else if (book.live_total <= goal) begin
				growing = 1'b1;
				goal = book.live_total + $urandom_range(64, 4);
				if (goal > TABLE_SLOTS || $urandom_range(4) < 2) goal = TABLE_SLOTS;
			end
			item = make_request(growing);
			// Push a few starts against a full table
			if (growing && book.live_total == TABLE_SLOTS && over_tries < 3) begin
				item.func = FUNC_START;
				over_tries++;
			end
			send_req(item);
		end
		req_valid = 1'b0;

		// Drain, then watch for stray results for one full scan
		while (book.results_due.size() != 0) @(posedge clk);
		repeat (TABLE_SLOTS + 8) @(posedge clk);

		$display("Starts: %0d placed, %0d refused on a full table; lookups: %0d hit, %0d missed",
			book.starts_done, book.starts_refused, book.lookups_hit, book.lookups_missed);
		$display("Destroys: %0d removed, %0d missed; unused codes: %0d; two %0d-cycle result holds",
			book.destroys_done, book.destroys_missed, book.unused_ops, HOLD_CYCLES);
		if (book.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
